/* rtl/gda_pkg.sv */
// Shared widths, constants, control word layout and microcode for the date adder.
`timescale 1ns / 1ps
package gda_pkg;

    localparam int DAYS_WIDTH = 20;
    localparam int YEAR_WIDTH = 14;
    localparam int DAY_W      = 5;
    localparam int MONTH_W    = 4;
    localparam int DACC_W     = DAYS_WIDTH + 1;
    localparam int DCMP_W     = (DACC_W > 18) ? DACC_W : 18;
    localparam int YM_W       = 9;
    localparam int CYCLE_DAYS = 146097;
    localparam int CYCLE_YEARS = 400;
    localparam int MIN_YEAR   = 1600;

    localparam logic [YEAR_WIDTH-1:0] YEAR_MAX = '1;
    localparam logic [MONTH_W-1:0]    MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0]    MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0]    MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]      DAY_LAST_DEC = 5'd31;

    // The month step falls through into the skip step after a December.
    typedef enum logic [2:0] {
        ST_MOD   = 3'd0,
        ST_CHECK = 3'd1,
        ST_MONTH = 3'd2,
        ST_SKIP  = 3'd3,
        ST_DONE  = 3'd4
    } t_step;

    typedef enum logic [2:0] {
        OP_MOD   = 3'd0,
        OP_CHECK = 3'd1,
        OP_SKIP  = 3'd2,
        OP_MONTH = 3'd3,
        OP_EMIT  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        COND_NEVER   = 3'd0,
        COND_ALWAYS  = 3'd1,
        COND_GE400   = 3'd2,
        COND_INVALID = 3'd3,
        COND_SKIP    = 3'd4,
        COND_STOP    = 3'd5,
        COND_WRAP    = 3'd6,
        COND_INYEAR  = 3'd7
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond_a;
        t_step tgt_a;
        t_cond cond_b;
        t_step tgt_b;
    } t_uword;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_ctrl;

    typedef struct packed {
        logic ge400;
        logic invalid;
        logic skip;
        logic stop;
        logic wrap;
    } t_stat;

    // Control store: one word per step.
    function automatic t_uword ucode(t_step pc);
        t_uword w;
        w = '{OP_EMIT, COND_ALWAYS, ST_MOD, COND_NEVER, ST_MOD};
        unique case (pc)
            ST_MOD:   w = '{OP_MOD,   COND_GE400,   ST_MOD,   COND_NEVER,  ST_MOD};
            ST_CHECK: w = '{OP_CHECK, COND_INVALID, ST_DONE,  COND_ALWAYS, ST_SKIP};
            ST_MONTH: w = '{OP_MONTH, COND_STOP,    ST_DONE,  COND_INYEAR, ST_MONTH};
            ST_SKIP:  w = '{OP_SKIP,  COND_SKIP,    ST_SKIP,  COND_ALWAYS, ST_MONTH};
            ST_DONE:  w = '{OP_EMIT,  COND_ALWAYS,  ST_MOD,   COND_NEVER,  ST_MOD};
            default:  w = '{OP_EMIT,  COND_ALWAYS,  ST_MOD,   COND_NEVER,  ST_MOD};
        endcase
        return w;
    endfunction

    // ym is the year modulo 400, y_lo the two low bits of the year.
    function automatic logic is_leap(logic [YM_W-1:0] ym, logic [1:0] y_lo);
        return (ym == YM_W'(0)) ||
               ((y_lo == 2'd0) && (ym != YM_W'(100)) && (ym != YM_W'(200)) &&
                (ym != YM_W'(300)));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(logic [MONTH_W-1:0] m, logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd0;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* rtl/gda_seq.sv */
// Microcode sequencer: step counter, control store fetch and conditional jumps.
`timescale 1ns / 1ps
module gda_seq import gda_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_stat i_stat,
    output t_ctrl o_ctrl,
    output logic  o_busy,
    output logic  o_done
);

    logic   r_busy, n_busy;
    logic   r_done, n_done;
    t_step  r_pc, n_pc;
    t_uword w_word;
    logic   w_hit_a, w_hit_b;

    function automatic logic cond_true(t_cond c, t_stat s);
        logic t;
        t = 1'b0;
        unique case (c)
            COND_NEVER:   t = 1'b0;
            COND_ALWAYS:  t = 1'b1;
            COND_GE400:   t = s.ge400;
            COND_INVALID: t = s.invalid;
            COND_SKIP:    t = s.skip;
            COND_STOP:    t = s.stop;
            COND_WRAP:    t = s.wrap;
            COND_INYEAR:  t = !s.wrap;
            default:      t = 1'b0;
        endcase
        return t;
    endfunction

    always_comb begin
        w_word  = ucode(r_pc);
        w_hit_a = cond_true(w_word.cond_a, i_stat);
        w_hit_b = cond_true(w_word.cond_b, i_stat);
        o_ctrl.load = i_accept;
        o_ctrl.op   = w_word.op;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_pc   = r_pc;
        if (i_accept) begin
            n_busy = 1'b1;
            n_pc   = ST_MOD;
        end else if (r_busy) begin
            priority if (w_hit_a) begin
                n_pc = w_word.tgt_a;
            end else if (w_hit_b) begin
                n_pc = w_word.tgt_b;
            end else begin
                n_pc = t_step'(r_pc + 3'd1);
            end
            if (w_word.op == OP_EMIT) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_pc   <= ST_MOD;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_pc   <= n_pc;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |=> r_busy) else $error("busy not raised after accept");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done strobe while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("done strobe longer than one cycle");
    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= ST_DONE)) else $error("step counter out of program");

endmodule

/* rtl/gda_dpath.sv */
// Datapath: date registers, month length lookup and the add/subtract unit.
`timescale 1ns / 1ps
module gda_dpath import gda_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_ctrl                 i_ctrl,
    input  logic [DAY_W-1:0]      i_start_day,
    input  logic [MONTH_W-1:0]    i_start_month,
    input  logic [YEAR_WIDTH-1:0] i_start_year,
    input  logic [DAYS_WIDTH-1:0] i_days_to_add,
    output t_stat                 o_stat,
    output logic [DAY_W-1:0]      o_end_day,
    output logic [MONTH_W-1:0]    o_end_month,
    output logic [YEAR_WIDTH-1:0] o_end_year,
    output logic                  o_date_valid,
    output logic                  o_year_overflow
);

    logic [DACC_W-1:0]     r_d, n_d;
    logic [MONTH_W-1:0]    r_m, n_m;
    logic [YEAR_WIDTH-1:0] r_y, n_y;
    logic [YEAR_WIDTH-1:0] r_ym, n_ym;
    logic [DAYS_WIDTH-1:0] r_add, n_add;
    logic                  r_valid, n_valid;
    logic                  r_ovf, n_ovf;

    logic                  w_leap;
    logic [DAY_W-1:0]      w_len;
    logic                  w_fit;
    logic                  w_date_ok;
    logic                  w_last_year;
    logic                  w_room;
    logic                  w_skip;

    always_comb begin
        w_leap      = is_leap(r_ym[YM_W-1:0], r_y[1:0]);
        w_len       = month_days(r_m, w_leap);
        w_fit       = r_d <= DACC_W'(w_len);
        w_date_ok   = (r_y > YEAR_WIDTH'(MIN_YEAR)) && (r_m >= MONTH_JAN) &&
                      (r_m <= MONTH_DEC) && (r_d != DACC_W'(0)) && w_fit;
        w_last_year = r_y == YEAR_MAX;
        w_room      = ({1'b0, r_y} + (YEAR_WIDTH+1)'(CYCLE_YEARS)) <= {1'b0, YEAR_MAX};
        w_skip      = (r_m == MONTH_JAN) && (DCMP_W'(r_d) > DCMP_W'(CYCLE_DAYS)) && w_room;

        o_stat.ge400   = r_ym >= YEAR_WIDTH'(CYCLE_YEARS);
        o_stat.invalid = !w_date_ok;
        o_stat.skip    = w_skip;
        o_stat.stop    = w_fit || ((r_m == MONTH_DEC) && w_last_year);
        o_stat.wrap    = r_m == MONTH_DEC;
    end

    always_comb begin
        n_d     = r_d;
        n_m     = r_m;
        n_y     = r_y;
        n_ym    = r_ym;
        n_add   = r_add;
        n_valid = r_valid;
        n_ovf   = r_ovf;
        if (i_ctrl.load) begin
            n_d     = DACC_W'(i_start_day);
            n_m     = i_start_month;
            n_y     = i_start_year;
            n_ym    = i_start_year;
            n_add   = i_days_to_add;
            n_valid = 1'b0;
            n_ovf   = 1'b0;
        end else begin
            unique case (i_ctrl.op)
                OP_MOD: begin
                    // reduce year mod 400 by repeated subtraction
                    if (o_stat.ge400) begin
                        n_ym = r_ym - YEAR_WIDTH'(CYCLE_YEARS);
                    end
                end
                OP_CHECK: begin
                    n_valid = w_date_ok;
                    if (w_date_ok) begin
                        n_d = r_d + DACC_W'(r_add);
                    end
                end
                OP_SKIP: begin
                    // jump a whole 400-year cycle; ym is unchanged
                    if (w_skip) begin
                        n_y = r_y + YEAR_WIDTH'(CYCLE_YEARS);
                        n_d = r_d - DACC_W'(CYCLE_DAYS);
                    end
                end
                OP_MONTH: begin
                    if (!w_fit) begin
                        if (r_m == MONTH_DEC) begin
                            if (w_last_year) begin
                                // saturate at the last day of the top year
                                n_d   = DACC_W'(DAY_LAST_DEC);
                                n_ovf = 1'b1;
                            end else begin
                                n_d  = r_d - DACC_W'(w_len);
                                n_m  = MONTH_JAN;
                                n_y  = r_y + YEAR_WIDTH'(1);
                                n_ym = (r_ym == YEAR_WIDTH'(CYCLE_YEARS - 1)) ?
                                       YEAR_WIDTH'(0) : r_ym + YEAR_WIDTH'(1);
                            end
                        end else begin
                            n_d = r_d - DACC_W'(w_len);
                            n_m = r_m + MONTH_W'(1);
                        end
                    end
                end
                OP_EMIT: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_d   <= n_d;
        r_m   <= n_m;
        r_y   <= n_y;
        r_ym  <= n_ym;
        r_add <= n_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_ovf   <= n_ovf;
        end
    end

    assign o_end_day       = r_d[DAY_W-1:0];
    assign o_end_month     = r_m;
    assign o_end_year      = r_y;
    assign o_date_valid    = r_valid;
    assign o_year_overflow = r_ovf;

    a_ovf_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_valid) else $error("overflow flagged on an invalid date");
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_m >= MONTH_JAN && r_m <= MONTH_DEC))
        else $error("month left 1..12 while walking");
    a_ym_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_ym < YEAR_WIDTH'(CYCLE_YEARS)))
        else $error("year residue not reduced below 400");

endmodule

/* rtl/gregorian_date_add_days.sv */
// Top level: adds a day count to a Gregorian date with a microcoded sequencer.
//
// Usage:
//   Drive the start date and day count and raise start while busy is low; the
//   transaction is taken at that clock edge and busy rises on the next cycle.
//   The inputs are sampled once and need not be held afterwards.
//   When the work is done busy falls and o_done is high for exactly one cycle
//   with the result on o_end_*, o_date_valid and o_year_overflow. The result
//   ports hold until the next transaction is taken; a new start may be given
//   in the o_done cycle itself. The receiver cannot stall the block.
// Steps of a transaction, from the accepting edge to the o_done cycle:
//   mod steps reduce the year modulo 400 by repeated subtraction, then a
//   check step, a skip step on entry and after each year wrap, repeated
//   while it jumps whole 400-year cycles, the month steps with a final one
//   that finds the day fits, and an emit step. Skips leave at most about
//   400 years to step a month at a time. An invalid date goes from the
//   check step straight to the emit step.
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// transaction in progress; no result is given for it.
`timescale 1ns / 1ps
module gregorian_date_add_days import gda_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DAY_W-1:0]      i_start_day,
    input  logic [MONTH_W-1:0]    i_start_month,
    input  logic [YEAR_WIDTH-1:0] i_start_year,
    input  logic [DAYS_WIDTH-1:0] i_days_to_add,
    output logic                  o_done,
    output logic [DAY_W-1:0]      o_end_day,
    output logic [MONTH_W-1:0]    o_end_month,
    output logic [YEAR_WIDTH-1:0] o_end_year,
    output logic                  o_date_valid,
    output logic                  o_year_overflow
);

    logic  w_accept;
    t_ctrl w_ctrl;
    t_stat w_stat;

    assign w_accept = start && !busy;

    gda_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_stat   (w_stat),
        .o_ctrl   (w_ctrl),
        .o_busy   (busy),
        .o_done   (o_done)
    );

    gda_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_start_day     (i_start_day),
        .i_start_month   (i_start_month),
        .i_start_year    (i_start_year),
        .i_days_to_add   (i_days_to_add),
        .o_stat          (w_stat),
        .o_end_day       (o_end_day),
        .o_end_month     (o_end_month),
        .o_end_year      (o_end_year),
        .o_date_valid    (o_date_valid),
        .o_year_overflow (o_year_overflow)
    );

endmodule
